@@ rtl/igmp_pkg.sv @@
`timescale 1ns / 1ps

package igmp_pkg;

    localparam int TABLE_ENTRIES_DEF  = 16;
    localparam int MIN_MESSAGE_LENGTH = 8;
    localparam int MAX_RESULTS        = 16;

    // remainder unit: bits retired per cycle and cycles per draw
    localparam int MOD_BITS_PER_CYCLE = 4;
    localparam int MOD_CYCLES         = 32 / MOD_BITS_PER_CYCLE;

    // operations
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_REPORT = 3'd2;
    localparam logic [2:0] OP_JOIN   = 3'd3;
    localparam logic [2:0] OP_LEAVE  = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_TOO_SHORT  = 3'd1;
    localparam logic [2:0] STAT_BAD_CKSUM  = 3'd2;
    localparam logic [2:0] STAT_BAD_QUERY  = 3'd3;
    localparam logic [2:0] STAT_BAD_REPORT = 3'd4;
    localparam logic [2:0] STAT_OUR_REPORT = 3'd5;
    localparam logic [2:0] STAT_TABLE_FULL = 3'd6;
    localparam logic [2:0] STAT_NOT_FOUND  = 3'd7;

    typedef struct packed {
        logic [31:0] all_hosts_group;
        logic [3:0]  loopback_interface;
        logic [7:0]  max_report_delay;
        logic        router_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  interface_req;
        logic [31:0] group_address;
        logic [31:0] destination_address;
        logic [15:0] message_length;
        logic        checksum_good;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        send_report;
        logic [31:0] report_group;
        logic [3:0]  report_interface;
        logic        loopback_request;
        logic        last;
    } out_item_t;

    // one membership table word
    typedef struct packed {
        logic [31:0] grp;
        logic [3:0]  ifc;
        logic [7:0]  cd;
    } entry_t;

endpackage

@@ rtl/igmp_ram.sv @@
`timescale 1ns / 1ps

module igmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/igmp_mod.sv @@
`timescale 1ns / 1ps

// 32-bit by 8-bit remainder, restoring, several bits per cycle
module igmp_mod
    import igmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [7:0]  remainder
);

    localparam int CW = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   dvd_reg;
    logic [31:0]   dvd_next;
    logic [7:0]    div_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    rem_next;

    always_comb begin
        logic [7:0]  r;
        logic [31:0] q;
        logic [8:0]  t;
        r = rem_reg;
        q = dvd_reg;
        t = '0;
        for (int k = 0; k < MOD_BITS_PER_CYCLE; k++) begin
            t = {r, q[31]};
            q = {q[30:0], 1'b0};
            if (t >= {1'b0, div_reg}) begin
                r = 8'(t - {1'b0, div_reg});
            end else begin
                r = t[7:0];
            end
        end
        rem_next = r;
        dvd_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(MOD_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/igmp_ctrl.sv @@
`timescale 1ns / 1ps

// sequencer: walks the membership table, reading and then evaluating each entry
module igmp_ctrl
    import igmp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam int EW = $bits(entry_t);
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_DRAW, S_FINISH} state_t;
    typedef enum logic [1:0] {M_TICK, M_QUERY, M_FIND} mode_t;

    function automatic out_item_t plain_result(input logic [2:0] st);
        out_item_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

    state_t             state_reg;
    mode_t              mode_reg;
    logic [2:0]         op_reg;
    logic [3:0]         ifc_reg;
    logic [31:0]        grp_reg;
    logic [IW-1:0]      idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic               found_reg;
    logic [IW-1:0]      found_idx_reg;
    logic               free_reg;
    logic [IW-1:0]      free_idx_reg;
    logic [IW-1:0]      tgt_idx_reg;
    logic               tgt_join_reg;
    logic [NW-1:0]      n_reg;
    logic [31:0]        lfsr_reg;
    logic               held_vld_reg;
    out_item_t          held_reg;
    logic               out_vld_reg;
    out_item_t          out_reg;

    // table memory port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [EW-1:0] ram_rdata;
    entry_t        rd;

    // remainder unit
    logic        mod_start;
    logic        mod_done;
    logic [7:0]  mod_rem;
    logic [7:0]  bound;
    logic [31:0] lfsr_next;

    // per-entry evaluation
    logic          out_free;
    logic          cur_valid;
    logic          last_idx;
    logic          tick_live;
    logic          tick_fire;
    logic          tick_stall;
    logic [7:0]    tick_cd;
    logic          q_hit;
    logic          f_hit;
    logic          found_now;
    logic [IW-1:0] found_idx_now;
    logic          free_now;
    logic [IW-1:0] free_idx_now;
    logic          join_dly;
    logic          join_end;
    out_item_t     fire_item;

    igmp_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    igmp_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (lfsr_next),
        .divisor   (bound),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign rd        = entry_t'(ram_rdata);
    assign bound     = (cfg.max_report_delay == 8'd0) ? 8'd1 : cfg.max_report_delay;
    assign lfsr_next = lfsr_step(lfsr_reg);
    assign out_free  = !out_vld_reg || m_ready;
    assign cur_valid = valid_reg[idx_reg];
    assign last_idx  = (idx_reg == IW'(TABLE_ENTRIES - 1));

    assign tick_cd    = rd.cd - 8'd1;
    assign tick_live  = cur_valid && (rd.cd != 8'd0) &&
                        !((rd.cd == 8'd1) && (n_reg == NW'(MAX_RESULTS)));
    assign tick_fire  = tick_live && (tick_cd == 8'd0);
    assign tick_stall = tick_fire && held_vld_reg && !out_free;

    assign q_hit = cur_valid && (rd.ifc == ifc_reg) && (rd.cd == 8'd0) &&
                   (rd.grp != cfg.all_hosts_group);
    assign f_hit = cur_valid && (rd.grp == grp_reg) && (rd.ifc == ifc_reg);

    assign found_now     = found_reg || f_hit;
    assign found_idx_now = found_reg ? found_idx_reg : idx_reg;
    assign free_now      = free_reg || !cur_valid;
    assign free_idx_now  = free_reg ? free_idx_reg : idx_reg;
    assign join_dly      = (grp_reg != cfg.all_hosts_group) &&
                           (ifc_reg != cfg.loopback_interface);
    // join that lands in a free slot at the end of the walk
    assign join_end      = (state_reg == S_EVAL) && (mode_reg == M_FIND) &&
                           (op_reg == OP_JOIN) && last_idx && !found_now && free_now;

    always_comb begin
        fire_item                  = '0;
        fire_item.status           = STAT_OK;
        fire_item.send_report      = 1'b1;
        fire_item.report_group     = rd.grp;
        fire_item.report_interface = rd.ifc;
        fire_item.loopback_request = cfg.router_mode;
    end

    assign mod_start = (state_reg == S_EVAL) &&
                       (((mode_reg == M_QUERY) && q_hit) || (join_end && join_dly));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{grp: rd.grp, ifc: rd.ifc, cd: 8'd0};
        case (state_reg)
            S_EVAL: begin
                case (mode_reg)
                    M_TICK: begin
                        if (tick_live && !tick_stall) begin
                            ram_we       = 1'b1;
                            ram_wdata.cd = tick_cd;
                        end
                    end
                    M_FIND: begin
                        if ((op_reg == OP_REPORT) && f_hit && !found_reg) begin
                            ram_we = 1'b1;
                        end else if (join_end && !join_dly) begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx_now;
                            ram_wdata = '{grp: grp_reg, ifc: ifc_reg, cd: 8'd0};
                        end
                    end
                    default: ;
                endcase
            end
            S_DRAW: begin
                if (mod_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = tgt_idx_reg;
                    ram_wdata = '{grp: tgt_join_reg ? grp_reg : rd.grp,
                                  ifc: tgt_join_reg ? ifc_reg : rd.ifc,
                                  cd:  mod_rem + 8'd1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_TICK;
            valid_reg    <= '0;
            lfsr_reg     <= LFSR_SEED;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            idx_reg      <= '0;
            n_reg        <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end else begin
            if (out_vld_reg && m_ready) begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_item.operation;
                        ifc_reg      <= s_item.interface_req;
                        grp_reg      <= s_item.group_address;
                        idx_reg      <= '0;
                        n_reg        <= '0;
                        found_reg    <= 1'b0;
                        free_reg     <= 1'b0;
                        held_vld_reg <= 1'b1;
                        held_reg     <= plain_result(STAT_OK);
                        state_reg    <= S_FINISH;
                        case (s_item.operation)
                            OP_TICK: begin
                                mode_reg     <= M_TICK;
                                held_vld_reg <= 1'b0;
                                state_reg    <= S_READ;
                            end
                            OP_QUERY, OP_REPORT: begin
                                if (s_item.message_length < 16'(MIN_MESSAGE_LENGTH)) begin
                                    held_reg <= plain_result(STAT_TOO_SHORT);
                                end else if (!s_item.checksum_good) begin
                                    held_reg <= plain_result(STAT_BAD_CKSUM);
                                end else if (s_item.interface_req ==
                                             cfg.loopback_interface) begin
                                    held_reg <= plain_result(STAT_OK);
                                end else if (s_item.operation == OP_QUERY) begin
                                    if (s_item.destination_address !=
                                        cfg.all_hosts_group) begin
                                        held_reg <= plain_result(STAT_BAD_QUERY);
                                    end else begin
                                        mode_reg  <= M_QUERY;
                                        state_reg <= S_READ;
                                    end
                                end else begin
                                    if ((s_item.group_address[31:28] != 4'hE) ||
                                        (s_item.group_address !=
                                         s_item.destination_address)) begin
                                        held_reg <= plain_result(STAT_BAD_REPORT);
                                    end else begin
                                        mode_reg     <= M_FIND;
                                        held_vld_reg <= 1'b0;
                                        state_reg    <= S_READ;
                                    end
                                end
                            end
                            OP_JOIN, OP_LEAVE: begin
                                mode_reg     <= M_FIND;
                                held_vld_reg <= 1'b0;
                                state_reg    <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end

                S_READ: begin
                    state_reg <= S_EVAL;
                end

                S_EVAL: begin
                    state_reg <= S_READ;
                    idx_reg   <= idx_reg + IW'(1);
                    case (mode_reg)
                        M_TICK: begin
                            if (tick_stall) begin
                                state_reg <= S_EVAL;
                                idx_reg   <= idx_reg;
                            end else begin
                                if (tick_fire) begin
                                    n_reg        <= n_reg + NW'(1);
                                    held_reg     <= fire_item;
                                    held_vld_reg <= 1'b1;
                                    if (held_vld_reg) begin
                                        out_vld_reg  <= 1'b1;
                                        out_reg      <= held_reg;
                                        out_reg.last <= 1'b0;
                                    end
                                end else if (last_idx && !held_vld_reg) begin
                                    held_reg     <= plain_result(STAT_OK);
                                    held_vld_reg <= 1'b1;
                                end
                                if (last_idx) begin
                                    state_reg <= S_FINISH;
                                end
                            end
                        end
                        M_QUERY: begin
                            if (q_hit) begin
                                lfsr_reg     <= lfsr_next;
                                tgt_idx_reg  <= idx_reg;
                                tgt_join_reg <= 1'b0;
                                idx_reg      <= idx_reg;
                                state_reg    <= S_DRAW;
                            end else if (last_idx) begin
                                state_reg <= S_FINISH;
                            end
                        end
                        default: begin
                            if (f_hit && !found_reg) begin
                                found_reg     <= 1'b1;
                                found_idx_reg <= idx_reg;
                            end
                            if (!cur_valid && !free_reg) begin
                                free_reg     <= 1'b1;
                                free_idx_reg <= idx_reg;
                            end
                            if (last_idx) begin
                                held_vld_reg <= 1'b1;
                                held_reg     <= plain_result(STAT_OK);
                                state_reg    <= S_FINISH;
                                case (op_reg)
                                    OP_REPORT: begin
                                        if (found_now) begin
                                            held_reg <= plain_result(STAT_OUR_REPORT);
                                        end
                                    end
                                    OP_LEAVE: begin
                                        if (found_now) begin
                                            valid_reg[found_idx_now] <= 1'b0;
                                        end else begin
                                            held_reg <= plain_result(STAT_NOT_FOUND);
                                        end
                                    end
                                    default: begin
                                        if (!found_now && !free_now) begin
                                            held_reg <= plain_result(STAT_TABLE_FULL);
                                        end else if (join_end) begin
                                            valid_reg[free_idx_now] <= 1'b1;
                                            if (join_dly) begin
                                                held_reg.send_report      <= 1'b1;
                                                held_reg.report_group     <= grp_reg;
                                                held_reg.report_interface <= ifc_reg;
                                                held_reg.loopback_request <=
                                                    cfg.router_mode;
                                                lfsr_reg     <= lfsr_next;
                                                tgt_idx_reg  <= free_idx_now;
                                                tgt_join_reg <= 1'b1;
                                                idx_reg      <= idx_reg;
                                                state_reg    <= S_DRAW;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end

                S_DRAW: begin
                    if (mod_done) begin
                        if (tgt_join_reg || last_idx) begin
                            state_reg <= S_FINISH;
                        end else begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end

                S_FINISH: begin
                    if (out_free) begin
                        out_vld_reg  <= 1'b1;
                        out_reg      <= held_reg;
                        out_reg.last <= 1'b1;
                        held_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

endmodule

@@ rtl/igmpv1_host_membership_engine_top.sv @@
`timescale 1ns / 1ps

// IGMPv1 host membership engine.
// Input stream (s_axis_*): one item per tick, received query, received report,
// join or leave; the operation code rides on tuser. Result stream (m_axis_*):
// one or more items per input item, tlast on the final one. A tick may give up
// to 16 report requests, in ascending table order; every other item gives one.
// Configuration goes through the APB port: all-hosts group, loopback interface,
// maximum report delay and router mode, at byte offsets 0, 4, 8 and 12.
// Items that need no table access go from idle straight to the finish state,
// which loads the result into the output register. Ticks, well-formed queries
// and reports, joins and leaves walk the table one entry at a time. Each random
// delay drawn (every idle entry hit by a query, and a join that starts a timer)
// waits on the shared 4-bit per cycle remainder unit. One item is in
// work at a time; tready is high only when the sequencer is idle.
// Reset clears all memberships, restores register defaults and reseeds the
// delay LFSR. When the receiver stalls, one result waits in the output register
// and one more in a holding register; the table walk pauses until room opens.
module igmpv1_host_membership_engine_top
    import igmp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] interface_req, [35:4] group_address, [67:36] destination_address,
    // [83:68] message_length, [84] checksum_good, [87:85] zero
    input  logic [87:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] send_report, [32:1] report_group, [36:33] report_interface,
    // [37] loopback_request, [39:38] zero
    output logic [39:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_ALL_HOSTS  = 2'd0;
    localparam logic [1:0] REG_LOOPBACK   = 2'd1;
    localparam logic [1:0] REG_MAX_DELAY  = 2'd2;
    localparam logic [1:0] REG_ROUTER     = 2'd3;

    logic [31:0] all_hosts_reg;
    logic [3:0]  loopback_reg;
    logic [7:0]  max_delay_reg;
    logic        router_reg;
    logic        cfg_wr;
    cfg_t        cfg;
    in_item_t    s_item;
    out_item_t   m_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_hosts_reg <= 32'hE000_0001;
            loopback_reg  <= 4'd0;
            max_delay_reg <= 8'd50;
            router_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ALL_HOSTS: all_hosts_reg <= pwdata;
                REG_LOOPBACK:  loopback_reg  <= pwdata[3:0];
                REG_MAX_DELAY: max_delay_reg <= pwdata[7:0];
                REG_ROUTER:    router_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ALL_HOSTS: prdata = all_hosts_reg;
            REG_LOOPBACK:  prdata = {28'd0, loopback_reg};
            REG_MAX_DELAY: prdata = {24'd0, max_delay_reg};
            REG_ROUTER:    prdata = {31'd0, router_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.all_hosts_group    = all_hosts_reg;
    assign cfg.loopback_interface = loopback_reg;
    assign cfg.max_report_delay   = max_delay_reg;
    assign cfg.router_mode        = router_reg;

    assign s_item.operation           = s_axis_tuser;
    assign s_item.interface_req       = s_axis_tdata[3:0];
    assign s_item.group_address       = s_axis_tdata[35:4];
    assign s_item.destination_address = s_axis_tdata[67:36];
    assign s_item.message_length      = s_axis_tdata[83:68];
    assign s_item.checksum_good       = s_axis_tdata[84];

    igmp_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_item  (m_item)
    );

    assign m_axis_tdata = {2'b00, m_item.loopback_request, m_item.report_interface,
                           m_item.report_group, m_item.send_report};
    assign m_axis_tuser = m_item.status;
    assign m_axis_tlast = m_item.last;

endmodule
